// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, muted while reset is high.
`define FCPB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define FCPB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/fcpb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcpb_pkg
// Shared types and constants of the frustum cull block.
// ----------------------------------------------------------------------------
package fcpb_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;

   localparam int NUM_PLANES = 6;
   localparam int NUM_ROWS   = 4;
   localparam int NUM_REGS   = 8;
   localparam int WORD_W     = 32;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int REG_IDX_W  = 3;
   localparam int ADDR_LSB   = 3;

   typedef logic [CSR_DATA_W-1:0] csr_word_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_ROW1_COLS12 = 3'd0,
      REG_ROW1_COLS34 = 3'd1,
      REG_ROW2_COLS12 = 3'd2,
      REG_ROW2_COLS34 = 3'd3,
      REG_ROW3_COLS12 = 3'd4,
      REG_ROW3_COLS34 = 3'd5,
      REG_ROW4_COLS12 = 3'd6,
      REG_ROW4_COLS34 = 3'd7
   } fcpb_reg_type;

   // Flags that ride along with each request through the cell row.
   typedef struct packed {
      logic func;     // 0 point test, 1 cube test
      logic culled;   // some earlier plane already rejected it
   } fcpb_flags_type;

   // Identity matrix in Q16.16.
   function automatic csr_word_type csr_reset_value(input fcpb_reg_type idx);
      csr_word_type v;
      v = '0;
      case (idx)
         REG_ROW1_COLS12: v = 64'h0000_0000_0001_0000;
         REG_ROW2_COLS12: v = 64'h0001_0000_0000_0000;
         REG_ROW3_COLS34: v = 64'h0000_0000_0001_0000;
         REG_ROW4_COLS34: v = 64'h0001_0000_0000_0000;
         default:         v = '0;
      endcase
      return v;
   endfunction

endpackage

// ----- design/frustum_cull_point_box_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_cull_point_box_top
// Six-plane frustum test of points and cubes against a Q16.16 matrix.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one request per valid/ready handshake carrying req_func
//    (0 point, 1 cube), center req_pos_x/y/z and half edge req_radius.
//  - rsp channel: one rsp_inside_res per request, in request order;
//    1 means inside, 0 means culled.
//  - csr port: APB, 64-bit data, matrix register i at byte address 8*i.
//    Write only while no request is in flight.
//  - Throughput: one request per cycle while rsp_ready stays high. Each of the
//    six plane cells is a three-stage pipe (request, products, partial sums;
//    the final sum and sign are combinational), and the row feeds the
//    response register that drives rsp_valid.
//  - Stalls: when rsp_ready is low the response register holds; bubbles
//    inside the row still close up, so requests keep being taken until
//    every stage is full.
//  - Reset: synchronous; empties the pipe and loads the identity matrix.
//    No warm-up; requests are taken the cycle after reset drops.
// ----------------------------------------------------------------------------

module frustum_cull_point_box_top #(
   parameter int COORD_WIDTH = fcpb_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = fcpb_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_func,
   input  logic signed [COORD_WIDTH-1:0]   req_pos_x,
   input  logic signed [COORD_WIDTH-1:0]   req_pos_y,
   input  logic signed [COORD_WIDTH-1:0]   req_pos_z,
   input  logic [COORD_WIDTH-2:0]          req_radius,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_inside_res,
   // configuration port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [fcpb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [fcpb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [fcpb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import fcpb_pkg::*;

   localparam int COEF_W = COORD_WIDTH + 1;

   csr_word_type matrix [NUM_REGS];

   // plane p uses column 4 plus (even p) or minus (odd p) column p/2 + 1
   logic signed [COEF_W-1:0] plane_coef [NUM_PLANES][NUM_ROWS];

   // links between cells; index 0 is the request port
   logic                          link_valid  [NUM_PLANES+1];
   logic                          link_ready  [NUM_PLANES+1];
   fcpb_flags_type                link_flags  [NUM_PLANES+1];
   logic signed [COORD_WIDTH-1:0] link_x      [NUM_PLANES+1];
   logic signed [COORD_WIDTH-1:0] link_y      [NUM_PLANES+1];
   logic signed [COORD_WIDTH-1:0] link_z      [NUM_PLANES+1];
   logic [COORD_WIDTH-2:0]        link_radius [NUM_PLANES+1];

   // response register
   logic out_valid_ff, out_valid_in;
   logic inside_ff;
   logic take_last;

   fcpb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .matrix      (matrix)
   );

   // Gribb-Hartmann extraction; words are the low COORD_WIDTH bits of each half
   for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
      localparam int K     = p / 2;
      localparam int E_LSB = (K % 2) * WORD_W;
      for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
         localparam int W_REG = 2 * r + 1;
         localparam int E_REG = 2 * r + K / 2;
         logic signed [COORD_WIDTH-1:0] w_s, e_s;
         assign w_s = matrix[W_REG][WORD_W +: COORD_WIDTH];
         assign e_s = matrix[E_REG][E_LSB +: COORD_WIDTH];
         if (p % 2 == 1) begin : g_sub
            assign plane_coef[p][r] = COEF_W'(w_s) - COEF_W'(e_s);
         end else begin : g_add
            assign plane_coef[p][r] = COEF_W'(w_s) + COEF_W'(e_s);
         end
      end
   end

   assign link_valid[0]        = req_valid;
   assign req_ready            = link_ready[0];
   assign link_flags[0].func   = req_func;
   assign link_flags[0].culled = 1'b0;
   assign link_x[0]            = req_pos_x;
   assign link_y[0]            = req_pos_y;
   assign link_z[0]            = req_pos_z;
   assign link_radius[0]       = req_radius;

   for (genvar p = 0; p < NUM_PLANES; p++) begin : g_cell
      fcpb_cell #(
         .COORD_WIDTH (COORD_WIDTH),
         .FRAC_BITS   (FRAC_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .plane_coef (plane_coef[p]),
         .up_valid   (link_valid[p]),
         .up_ready   (link_ready[p]),
         .up_flags   (link_flags[p]),
         .up_pos_x   (link_x[p]),
         .up_pos_y   (link_y[p]),
         .up_pos_z   (link_z[p]),
         .up_radius  (link_radius[p]),
         .dn_valid   (link_valid[p+1]),
         .dn_ready   (link_ready[p+1]),
         .dn_flags   (link_flags[p+1]),
         .dn_pos_x   (link_x[p+1]),
         .dn_pos_y   (link_y[p+1]),
         .dn_pos_z   (link_z[p+1]),
         .dn_radius  (link_radius[p+1])
      );
   end

   // last cell drains into the response register when it is free or leaving
   assign link_ready[NUM_PLANES] = !out_valid_ff || rsp_ready;
   assign take_last              = link_valid[NUM_PLANES] && link_ready[NUM_PLANES];
   assign out_valid_in           = take_last || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_last) begin
         inside_ff <= !link_flags[NUM_PLANES].culled;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_inside_res = inside_ff;

endmodule

// ----- design/fcpb_csr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcpb_csr
// APB register file holding the view-projection matrix.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcpb_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [fcpb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [fcpb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [fcpb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output fcpb_pkg::csr_word_type          matrix [fcpb_pkg::NUM_REGS]
);
   import fcpb_pkg::*;

   csr_word_type           regs_ff [NUM_REGS];
   logic                   wr_en;
   logic [REG_IDX_W-1:0]   idx;

   assign idx        = csr_paddr[CSR_ADDR_W-1:ADDR_LSB];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = regs_ff[idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= csr_reset_value(fcpb_reg_type'(REG_IDX_W'(i)));
         end
      end else if (wr_en) begin
         regs_ff[idx] <= csr_pwdata;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_REGS; i++) begin
         matrix[i] = regs_ff[i];
      end
   end

   `FCPB_ASSERT(a_write_lands, clock, reset, wr_en |=> (regs_ff[$past(idx)] == $past(csr_pwdata)), "csr write lost")
   `FCPB_ASSERT(a_reset_identity, clock, reset, $past(reset) |-> (regs_ff[REG_ROW1_COLS12] == csr_reset_value(REG_ROW1_COLS12)) && (regs_ff[REG_ROW4_COLS34] == csr_reset_value(REG_ROW4_COLS34)), "csr reset value wrong")
   `FCPB_ASSERT(a_hold_no_write, clock, reset, (!wr_en && !reset) |=> $stable(regs_ff[0]) && $stable(regs_ff[7]), "csr changed without write")

endmodule

// ----- design/fcpb_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcpb_cell
// One clip plane: holds its coefficients, tests a request, passes it on.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcpb_cell #(
   parameter int COORD_WIDTH = fcpb_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = fcpb_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // plane coefficients a, b, c, d
   input  logic signed [COORD_WIDTH:0]   plane_coef [fcpb_pkg::NUM_ROWS],
   // upstream side
   input  logic                          up_valid,
   output logic                          up_ready,
   input  fcpb_pkg::fcpb_flags_type      up_flags,
   input  logic signed [COORD_WIDTH-1:0] up_pos_x,
   input  logic signed [COORD_WIDTH-1:0] up_pos_y,
   input  logic signed [COORD_WIDTH-1:0] up_pos_z,
   input  logic [COORD_WIDTH-2:0]        up_radius,
   // downstream side
   output logic                          dn_valid,
   input  logic                          dn_ready,
   output fcpb_pkg::fcpb_flags_type      dn_flags,
   output logic signed [COORD_WIDTH-1:0] dn_pos_x,
   output logic signed [COORD_WIDTH-1:0] dn_pos_y,
   output logic signed [COORD_WIDTH-1:0] dn_pos_z,
   output logic [COORD_WIDTH-2:0]        dn_radius
);
   import fcpb_pkg::*;

   localparam int COEF_W = COORD_WIDTH + 1;
   localparam int SABS_W = COORD_WIDTH + 2;
   localparam int PROD_W = 2 * COORD_WIDTH + 1;
   localparam int ACC_W  = 2 * COORD_WIDTH + 4;

   function automatic logic [COEF_W-1:0] mag_of(input logic signed [COEF_W-1:0] v);
      logic [COEF_W-1:0] u;
      u = v;
      return u[COEF_W-1] ? (~u + COEF_W'(1)) : u;
   endfunction

   // coefficient state
   logic signed [COEF_W-1:0] coef_ff [NUM_ROWS];
   logic [SABS_W-1:0]        sabs_ff;
   logic [SABS_W-1:0]        sabs_in;

   // pipeline control
   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;
   logic en1, en2, en3;

   // stage 1: request
   fcpb_flags_type                flags1_ff;
   logic signed [COORD_WIDTH-1:0] x1_ff, y1_ff, z1_ff;
   logic [COORD_WIDTH-2:0]        r1_ff;

   // stage 2: products
   fcpb_flags_type                flags2_ff;
   logic signed [COORD_WIDTH-1:0] x2_ff, y2_ff, z2_ff;
   logic [COORD_WIDTH-2:0]        r2_ff;
   logic signed [PROD_W-1:0]      pa_ff, pb_ff, pc_ff;
   logic signed [PROD_W-1:0]      pa_in, pb_in, pc_in;
   logic [PROD_W-1:0]             pr_ff, pr_in;

   // stage 3: partial sums
   fcpb_flags_type                flags3_ff;
   logic signed [COORD_WIDTH-1:0] x3_ff, y3_ff, z3_ff;
   logic [COORD_WIDTH-2:0]        r3_ff;
   logic signed [ACC_W-1:0]       sab_ff, scdr_ff, sab_in, scdr_in;

   logic signed [ACC_W-1:0]       total;
   logic                          hit;

   assign sabs_in = SABS_W'(mag_of(plane_coef[0])) + SABS_W'(mag_of(plane_coef[1]))
                  + SABS_W'(mag_of(plane_coef[2]));

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_ROWS; i++) begin
         coef_ff[i] <= plane_coef[i];
      end
      sabs_ff <= sabs_in;
   end

   // stall chain: a stage moves when empty or when the next one moves
   assign en3      = !v3_ff || dn_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign up_ready = en1;

   assign v1_in = en1 ? up_valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   assign pa_in = coef_ff[0] * x1_ff;
   assign pb_in = coef_ff[1] * y1_ff;
   assign pc_in = coef_ff[2] * z1_ff;
   assign pr_in = flags1_ff.func ? (PROD_W'(r1_ff) * PROD_W'(sabs_ff)) : '0;

   assign sab_in  = ACC_W'(pa_ff) + ACC_W'(pb_ff);
   assign scdr_in = ACC_W'(pc_ff) + (ACC_W'(coef_ff[3]) <<< FRAC_BITS)
                  + $signed(ACC_W'(pr_ff));

   always_ff @(posedge clock) begin
      if (en1) begin
         flags1_ff <= up_flags;
         x1_ff     <= up_pos_x;
         y1_ff     <= up_pos_y;
         z1_ff     <= up_pos_z;
         r1_ff     <= up_radius;
      end
      if (en2) begin
         flags2_ff <= flags1_ff;
         x2_ff     <= x1_ff;
         y2_ff     <= y1_ff;
         z2_ff     <= z1_ff;
         r2_ff     <= r1_ff;
         pa_ff     <= pa_in;
         pb_ff     <= pb_in;
         pc_ff     <= pc_in;
         pr_ff     <= pr_in;
      end
      if (en3) begin
         flags3_ff <= flags2_ff;
         x3_ff     <= x2_ff;
         y3_ff     <= y2_ff;
         z3_ff     <= z2_ff;
         r3_ff     <= r2_ff;
         sab_ff    <= sab_in;
         scdr_ff   <= scdr_in;
      end
   end

   // points cull below zero, cubes at or below zero
   assign total = sab_ff + scdr_ff;
   assign hit   = total[ACC_W-1] || (flags3_ff.func && (total == '0));

   assign dn_valid        = v3_ff;
   assign dn_flags.func   = flags3_ff.func;
   assign dn_flags.culled = flags3_ff.culled || hit;
   assign dn_pos_x        = x3_ff;
   assign dn_pos_y        = y3_ff;
   assign dn_pos_z        = z3_ff;
   assign dn_radius       = r3_ff;

   `FCPB_ASSERT(a_empty_takes, clock, reset, !v1_ff |-> up_ready, "empty cell refused request")
   `FCPB_ASSERT(a_out_holds, clock, reset, (v3_ff && !dn_ready) |=> v3_ff && $stable(flags3_ff) && $stable(sab_ff), "stalled cell output moved")
   `FCPB_ASSERT(a_in_holds, clock, reset, (v1_ff && !en2) |=> v1_ff && $stable(flags1_ff) && $stable(x1_ff), "stalled first stage lost request")

endmodule
